/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL, clocked on clk_i; M7_ASSERT is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property while out of reset
`define M7_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property at every edge, reset included
`define M7_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/m7mul_pkg.sv */
// Package with bus codes, register addresses and decode helpers for the mode 7 multiplier unit
`default_nettype none

package m7mul_pkg;

  localparam int unsigned AddrW    = 24;
  localparam int unsigned DecAddrW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RegW     = 16;
  localparam int unsigned ProdW    = 24;

  typedef logic [DecAddrW-1:0] dec_addr_t;
  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [RegW-1:0]     reg16_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } bus_op_e;

  localparam dec_addr_t ADDR_MPYL = 16'h2134;
  localparam dec_addr_t ADDR_MPYM = 16'h2135;
  localparam dec_addr_t ADDR_MPYH = 16'h2136;
  localparam dec_addr_t ADDR_M7A  = 16'h211B;
  localparam dec_addr_t ADDR_M7B  = 16'h211C;
  localparam dec_addr_t ADDR_M7C  = 16'h211D;
  localparam dec_addr_t ADDR_M7D  = 16'h211E;
  localparam dec_addr_t ADDR_M7X  = 16'h211F;
  localparam dec_addr_t ADDR_M7Y  = 16'h2120;

  function automatic logic is_write_only(input dec_addr_t a);
    logic r;
    case (a)
      16'h2104, 16'h2105, 16'h2106, 16'h2108,
      16'h2109, 16'h210A, 16'h2114, 16'h2115,
      16'h2116, 16'h2118, 16'h2119, 16'h211A,
      16'h2124, 16'h2125, 16'h2126, 16'h2128,
      16'h2129, 16'h212A: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/mode7_matrix_register_multiplier_unit.sv */
// Mode 7 matrix register block with signed 16x8 multiplier readback
`default_nettype none

`include "assert_macros.svh"

// Takes one bus beat per cycle while in_ready_o is high. Each beat is captured
// in an input register and decoded against the matrix registers as it leaves:
// writes update the registers; reads of MPYL/M/H take their byte from a signed
// 16x8 multiply of matrix A by the high byte of matrix B, reads of write-only
// addresses the last product byte read, other reads their own data byte, all
// into the output register. Sustained rate is one beat per cycle, limited only
// by the output register: a read waiting in the input stage while the output
// is stalled holds in_ready_o low. Writes give no result beat; reads always give exactly one.
module mode7_matrix_register_multiplier_unit
  import m7mul_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             op_i,
  input  wire logic [AddrW-1:0] address_i,
  input  wire logic [ByteW-1:0] data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      read_data_o
);

  logic      s1_valid_q;
  bus_op_e   s1_op_q;
  dec_addr_t s1_addr_q;
  byte_t     s1_data_q;

  byte_t  write_latch_q, write_latch_d;
  reg16_t matrix_a_q, matrix_a_d;
  reg16_t matrix_b_q, matrix_b_d;
  reg16_t matrix_c_q, matrix_c_d;
  reg16_t matrix_d_q, matrix_d_d;
  reg16_t center_x_q, center_x_d;
  reg16_t center_y_q, center_y_d;
  byte_t  last_read_q, last_read_d;

  logic  out_valid_q, out_valid_d;
  byte_t read_data_q, read_data_d;

  logic             is_read;
  logic             rd_blocked;
  logic             advance;
  logic             wr_adv;
  logic             mpy_adv;
  logic [ProdW-1:0] product;
  reg16_t           wr_value;

  assign is_read    = (s1_op_q == OP_READ);
  assign rd_blocked = is_read && out_valid_q && !out_ready_i;
  assign advance    = s1_valid_q && !rd_blocked;
  assign in_ready_o = !s1_valid_q || advance;
  assign wr_adv     = advance && !is_read;
  assign mpy_adv    = advance && is_read &&
                      (s1_addr_q == ADDR_MPYL || s1_addr_q == ADDR_MPYM ||
                       s1_addr_q == ADDR_MPYH);

  assign product  = $signed({{ByteW{matrix_a_q[RegW-1]}}, matrix_a_q}) *
                    $signed({{RegW{matrix_b_q[RegW-1]}}, matrix_b_q[RegW-1:ByteW]});
  assign wr_value = {s1_data_q, write_latch_q};

  always_comb begin
    write_latch_d = write_latch_q;
    matrix_a_d    = matrix_a_q;
    matrix_b_d    = matrix_b_q;
    matrix_c_d    = matrix_c_q;
    matrix_d_d    = matrix_d_q;
    center_x_d    = center_x_q;
    center_y_d    = center_y_q;
    last_read_d   = last_read_q;
    read_data_d   = read_data_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    if (advance) begin
      if (!is_read) begin
        case (s1_addr_q)
          ADDR_M7A: begin
            matrix_a_d    = wr_value;
            write_latch_d = s1_data_q;
          end
          ADDR_M7B: begin
            matrix_b_d    = wr_value;
            write_latch_d = s1_data_q;
          end
          ADDR_M7C: begin
            matrix_c_d    = wr_value;
            write_latch_d = s1_data_q;
          end
          ADDR_M7D: begin
            matrix_d_d    = wr_value;
            write_latch_d = s1_data_q;
          end
          ADDR_M7X: begin
            center_x_d    = wr_value;
            write_latch_d = s1_data_q;
          end
          ADDR_M7Y: begin
            center_y_d    = wr_value;
            write_latch_d = s1_data_q;
          end
          default: begin
          end
        endcase
      end else begin
        out_valid_d = 1'b1;
        case (s1_addr_q)
          ADDR_MPYL: begin
            read_data_d = product[ByteW-1:0];
            last_read_d = product[ByteW-1:0];
          end
          ADDR_MPYM: begin
            read_data_d = product[2*ByteW-1:ByteW];
            last_read_d = product[2*ByteW-1:ByteW];
          end
          ADDR_MPYH: begin
            read_data_d = product[3*ByteW-1:2*ByteW];
            last_read_d = product[3*ByteW-1:2*ByteW];
          end
          default: begin
            read_data_d = is_write_only(s1_addr_q) ? last_read_q : s1_data_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      write_latch_q <= '0;
      matrix_a_q    <= '0;
      matrix_b_q    <= '0;
      matrix_c_q    <= '0;
      matrix_d_q    <= '0;
      center_x_q    <= '0;
      center_y_q    <= '0;
      last_read_q   <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      out_valid_q   <= out_valid_d;
      write_latch_q <= write_latch_d;
      matrix_a_q    <= matrix_a_d;
      matrix_b_q    <= matrix_b_d;
      matrix_c_q    <= matrix_c_d;
      matrix_d_q    <= matrix_d_d;
      center_x_q    <= center_x_d;
      center_y_q    <= center_y_d;
      last_read_q   <= last_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= bus_op_e'(op_i);
      s1_addr_q <= address_i[DecAddrW-1:0];
      s1_data_q <= data_i;
    end
    read_data_q <= read_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  `M7_ASSERT(a_stall_cause, !in_ready_o |-> rd_blocked, "input stall without blocked read")
  `M7_ASSERT(a_write_no_beat, wr_adv && out_ready_i |=> !out_valid_q, "write gave a beat")
  `M7_ASSERT(a_mpy_last_read, mpy_adv |=> last_read_q == read_data_q, "last-read byte stale")

endmodule

`default_nettype wire
